[sv/pfla_pkg.sv]
package pfla_pkg;

    // Widths of a page index and of a list link (the link carries an empty mark).
    localparam int PAGE_W  = 16;
    localparam int LINK_W  = 17;
    localparam int COUNT_W = 16;

    localparam logic [LINK_W-1:0] MAX_PAGES  = 17'h10000;
    localparam logic [LINK_W-1:0] LIST_EMPTY = 17'h10000;

    // Operation codes.
    localparam logic [2:0] OP_INIT   = 3'd0;
    localparam logic [2:0] OP_ALLOC  = 3'd1;
    localparam logic [2:0] OP_FREE   = 3'd2;
    localparam logic [2:0] OP_INCREF = 3'd3;
    localparam logic [2:0] OP_DECREF = 3'd4;

    // Status codes.
    localparam logic [2:0] STS_OK      = 3'd0;
    localparam logic [2:0] STS_NOINIT  = 3'd1;
    localparam logic [2:0] STS_EMPTY   = 3'd2;
    localparam logic [2:0] STS_BADPAGE = 3'd3;
    localparam logic [2:0] STS_INUSE   = 3'd4;
    localparam logic [2:0] STS_ISFREE  = 3'd5;
    localparam logic [2:0] STS_LIMIT   = 3'd6;
    localparam logic [2:0] STS_REINIT  = 3'd7;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_PAGE_COUNT  = 2'd0;
    localparam logic [1:0] REG_HEAP_START  = 2'd1;
    localparam logic [1:0] REG_KERNEL_PAGE = 2'd2;

    // One page entry of the memory.
    typedef struct packed {
        logic                is_free;
        logic [LINK_W-1:0]   link;
        logic [COUNT_W-1:0]  ref_cnt;
    } entry_t;

    // Memory request from the controller.
    typedef struct packed {
        logic                we;
        logic [PAGE_W-1:0]   waddr;
        entry_t              wdata;
        logic                re;
        logic [PAGE_W-1:0]   raddr;
    } ram_req_t;

    // Configuration register values.
    typedef struct packed {
        logic [LINK_W-1:0]   page_count;
        logic [PAGE_W-1:0]   heap_start;
        logic [PAGE_W-1:0]   kernel_first_page;
    } cfg_t;

    // One result item, page_index in the lowest bits.
    typedef struct packed {
        logic                freed;
        logic [COUNT_W-1:0]  ref_count;
        logic [2:0]          status;
        logic [PAGE_W-1:0]   page_index;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_EXEC
    } state_t;

endpackage

[sv/pfla_page_ram.sv]
module pfla_page_ram (
    input  logic              clk,
    input  pfla_pkg::ram_req_t req,
    output pfla_pkg::entry_t   rdata
);
    import pfla_pkg::*;

    localparam int DEPTH = 1 << PAGE_W;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/pfla_cfg.sv]
module pfla_cfg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output pfla_pkg::cfg_t    cfg
);
    import pfla_pkg::*;

    logic [LINK_W-1:0] page_count_reg;
    logic [PAGE_W-1:0] heap_start_reg;
    logic [PAGE_W-1:0] kernel_page_reg;
    logic              wr_en;
    logic [1:0]        reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes on the access cycle of a write request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_count_reg  <= MAX_PAGES;
            heap_start_reg  <= 16'd512;
            kernel_page_reg <= 16'd256;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_PAGE_COUNT:  page_count_reg  <= pwdata[LINK_W-1:0];
                REG_HEAP_START:  heap_start_reg  <= pwdata[PAGE_W-1:0];
                REG_KERNEL_PAGE: kernel_page_reg <= pwdata[PAGE_W-1:0];
                default:         ;
            endcase
        end
    end

    // Read-back.
    always_comb
    begin
        case (reg_sel)
            REG_PAGE_COUNT:  prdata = {15'd0, page_count_reg};
            REG_HEAP_START:  prdata = {16'd0, heap_start_reg};
            REG_KERNEL_PAGE: prdata = {16'd0, kernel_page_reg};
            default:         prdata = 32'd0;
        endcase
    end

    assign cfg.page_count        = page_count_reg;
    assign cfg.heap_start        = heap_start_reg;
    assign cfg.kernel_first_page = kernel_page_reg;

endmodule

[sv/pfla_ctrl.sv]
module pfla_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [2:0]         s_tuser,
    input  logic [15:0]        s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    output pfla_pkg::result_t  result,
    input  pfla_pkg::cfg_t     cfg,
    output pfla_pkg::ram_req_t ram_req,
    input  pfla_pkg::entry_t   ram_rdata
);
    import pfla_pkg::*;

    state_t            state_reg, state_next;
    logic [2:0]        op_reg, op_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic              ready_reg, ready_next;
    logic [LINK_W-1:0] head_reg, head_next;
    logic [LINK_W-1:0] limit_reg, limit_next;
    logic [LINK_W-1:0] idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_data_reg, out_data_next;

    logic              accept;
    logic              out_free;
    logic              walk_done;
    logic [LINK_W-1:0] idx_plus;
    logic [LINK_W-1:0] sat_count;
    logic              kernel_hit;
    logic              counted_ok;
    logic              in_range;
    logic [COUNT_W-1:0] dec_cnt;
    result_t           res;
    entry_t            wr_entry;
    logic              wr_en;
    logic [LINK_W-1:0] head_upd;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign walk_done = (idx_reg == limit_reg);
    assign idx_plus  = idx_reg + 1'b1;
    assign sat_count = (cfg.page_count > MAX_PAGES) ? MAX_PAGES : cfg.page_count;

    assign m_tvalid = out_valid_reg;
    assign result   = out_data_reg;

    // Page checks for the item held in execution.
    assign in_range   = ({1'b0, page_reg} < limit_reg);
    assign kernel_hit = (page_reg >= cfg.kernel_first_page) && (page_reg < cfg.heap_start);
    assign counted_ok = (page_reg >= 16'd2) && in_range && !kernel_hit;
    assign dec_cnt    = ram_rdata.ref_cnt - 1'b1;

    // Result and write-back of one executed item, from the entry read.
    always_comb
    begin
        res            = '0;
        res.page_index = page_reg;
        res.status     = STS_OK;
        wr_entry       = ram_rdata;
        wr_en          = 1'b0;
        head_upd       = head_reg;

        if (op_reg == OP_INIT)
        begin
            if (ready_reg)
            begin
                res.status = STS_REINIT;
            end
        end
        else if (op_reg > OP_DECREF)
        begin
            res.status = STS_OK;
        end
        else if (!ready_reg)
        begin
            res.status = STS_NOINIT;
        end
        else if (op_reg == OP_ALLOC)
        begin
            if (head_reg == LIST_EMPTY)
            begin
                res.status     = STS_EMPTY;
                res.page_index = '0;
            end
            else
            begin
                res.page_index   = head_reg[PAGE_W-1:0];
                res.ref_count    = ram_rdata.ref_cnt;
                wr_entry.is_free = 1'b0;
                wr_en            = 1'b1;
                head_upd         = ram_rdata.link;
            end
        end
        else if (op_reg == OP_FREE)
        begin
            if (!in_range)
            begin
                res.status = STS_BADPAGE;
            end
            else
            begin
                res.ref_count = ram_rdata.ref_cnt;
                if (ram_rdata.ref_cnt != '0)
                begin
                    res.status = STS_INUSE;
                end
                else if (ram_rdata.is_free)
                begin
                    res.status = STS_ISFREE;
                end
                else
                begin
                    wr_entry.is_free = 1'b1;
                    wr_entry.link    = head_reg;
                    wr_en            = 1'b1;
                    head_upd         = {1'b0, page_reg};
                end
            end
        end
        else if (!counted_ok)
        begin
            res.status = STS_BADPAGE;
        end
        else if (op_reg == OP_INCREF)
        begin
            res.ref_count = ram_rdata.ref_cnt;
            if (ram_rdata.ref_cnt == '1)
            begin
                res.status = STS_LIMIT;
            end
            else
            begin
                res.ref_count    = ram_rdata.ref_cnt + 1'b1;
                wr_entry.ref_cnt = ram_rdata.ref_cnt + 1'b1;
                wr_en            = 1'b1;
            end
        end
        else
        begin
            // Decrement; reaching zero returns the page to the list unless it is already free.
            if (ram_rdata.ref_cnt == '0)
            begin
                res.status = STS_LIMIT;
            end
            else
            begin
                res.ref_count    = dec_cnt;
                wr_entry.ref_cnt = dec_cnt;
                wr_en            = 1'b1;
                if (dec_cnt == '0)
                begin
                    if (ram_rdata.is_free)
                    begin
                        res.status = STS_ISFREE;
                    end
                    else
                    begin
                        wr_entry.is_free = 1'b1;
                        wr_entry.link    = head_reg;
                        head_upd         = {1'b0, page_reg};
                        res.freed        = 1'b1;
                    end
                end
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((s_tuser == OP_INIT) && !ready_reg)
                    begin
                        state_next = ST_INIT;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_INIT:
            begin
                if (walk_done)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory requests per state.
    always_comb
    begin
        op_next        = op_reg;
        page_next      = page_reg;
        ready_next     = ready_reg;
        head_next      = head_reg;
        limit_next     = limit_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        ram_req        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next       = s_tuser;
                    page_next     = s_tdata;
                    ram_req.re    = 1'b1;
                    ram_req.raddr = (s_tuser == OP_ALLOC) ? head_reg[PAGE_W-1:0] : s_tdata;
                    if ((s_tuser == OP_INIT) && !ready_reg)
                    begin
                        limit_next = sat_count;
                        idx_next   = '0;
                        head_next  = ({1'b0, cfg.heap_start} < sat_count) ?
                                     {1'b0, cfg.heap_start} : LIST_EMPTY;
                    end
                end
            end
            ST_INIT:
            begin
                // One page written per cycle; free pages chained in ascending order.
                if (!walk_done)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = idx_reg[PAGE_W-1:0];
                    if (idx_reg >= {1'b0, cfg.heap_start})
                    begin
                        ram_req.wdata.is_free = 1'b1;
                        ram_req.wdata.link    = (idx_plus < limit_reg) ? idx_plus : LIST_EMPTY;
                        ram_req.wdata.ref_cnt = '0;
                    end
                    else
                    begin
                        ram_req.wdata.is_free = 1'b0;
                        ram_req.wdata.link    = LIST_EMPTY;
                        ram_req.wdata.ref_cnt = 16'd1;
                    end
                    idx_next = idx_plus;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res;
                    head_next      = head_upd;
                    ram_req.we     = wr_en;
                    ram_req.waddr  = res.page_index;
                    ram_req.wdata  = wr_entry;
                    if (op_reg == OP_INIT)
                    begin
                        ready_next = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ready_reg     <= 1'b0;
            head_reg      <= LIST_EMPTY;
            limit_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ready_reg     <= ready_next;
            head_reg      <= head_next;
            limit_reg     <= limit_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        page_reg     <= page_next;
        out_data_reg <= out_data_next;
    end

endmodule

[sv/page_free_list_allocator.sv]
// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid/s_tready    s_tuser operation, s_tdata page
// m_        out        m_tvalid/m_tready    m_tdata page_index, status, ref_count, freed
// APB       in         psel/penable/pready  page_count, heap_start, kernel_first_page
//
// Each request first reads the page entry from the page memory, then modifies it,
// writes it back and loads the result register.
// Init writes one memory entry per page, up to the page count latched at its start.
// Reset clears only control state; memory contents are undefined until init.
// A result waits in the output register while the next request is accepted;
// execution stalls only when that register is still full.
module page_free_list_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // operation
    input  logic [15:0] s_tdata,   // page
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // page_index[15:0], status[18:16], ref_count[34:19], freed[35]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pfla_pkg::*;

    cfg_t     cfg;
    ram_req_t ram_req;
    entry_t   ram_rdata;
    result_t  result;

    // Configuration registers.
    pfla_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Page entry memory.
    pfla_page_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    // Request sequencing and read-modify-write.
    pfla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .result    (result),
        .cfg       (cfg),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    assign m_tdata = {4'd0, result};

endmodule
